/* sv/swl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swl_pkg: shared types and constants for the sliding-window limiter
// Widths, configuration register indexes and the word formats passed
// between the limiter core and its output queue.
// ----------------------------------------------------------------------------
package swl_pkg;

    // Arrival types; a power of two, so the type reduces by truncation
    localparam int NUM_TYPES  = 1024;
    localparam int TYPE_W     = $clog2(NUM_TYPES);
    localparam int ARR_W      = 10;

    // Window ring; a power of two, so the position wraps by itself
    localparam int WINDOW_MAX = 256;
    localparam int POS_W      = $clog2(WINDOW_MAX);
    localparam int SEEN_W     = POS_W + 1;

    // Per-type counts, kept as two wrapping counters (kept in, kept out)
    localparam int CNT_W      = 9;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int TOTAL_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_TYPE  = CFG_IDX_W'(1);

    // Output queue
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic               kept;
        logic [TYPE_W-1:0]  kind;
    } t_slot;

    typedef struct packed {
        logic               discarded;
        logic [TOTAL_W-1:0] discard_total;
    } t_result;

endpackage
`default_nettype wire

/* sv/sliding_window_per_type_limiter.sv */
`default_nettype none
// An accepted word is registered in stage 1; its result then enters the queue that feeds the outputs.
// Throughput: one word per cycle while o_stall is low; two read ports per count memory plus write
//   forwarding let every word do its increment and its decrement in flight.
// Reset: after i_rst_n the count memories are swept to zero, one entry a cycle, over all 1024
//   entries with the input stalled; configuration writes are taken.
// ----------------------------------------------------------------------------
// sliding_window_per_type_limiter: per-type arrival limiter over a sliding window
// Counts kept arrivals per type over the last window_length words and drops
// arrivals that would exceed max_per_type, with a saturating drop total.
// ----------------------------------------------------------------------------
module sliding_window_per_type_limiter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [swl_pkg::ARR_W-1:0]      i_arrival_type,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_discarded,
    output logic [swl_pkg::TOTAL_W-1:0]         o_discard_total,
    input  wire logic                           i_cfg_we,
    input  wire logic [swl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swl_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int TYPE_W  = swl_pkg::TYPE_W;
    localparam int POS_W   = swl_pkg::POS_W;
    localparam int SEEN_W  = swl_pkg::SEEN_W;
    localparam int CNT_W   = swl_pkg::CNT_W;
    localparam int CFG_W   = swl_pkg::CFG_W;
    localparam int TOTAL_W = swl_pkg::TOTAL_W;
    localparam int QCNT_W  = swl_pkg::OUT_PTR_W + 1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_wl;
    logic [CFG_W-1:0] r_mpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl  <= CFG_W'(1);
            r_mpt <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swl_pkg::REG_WINDOW_LENGTH: r_wl  <= i_cfg_data;
                swl_pkg::REG_MAX_PER_TYPE:  r_mpt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Memories: kept-in and kept-out counters per type, window ring
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]    r_inc_mem  [swl_pkg::NUM_TYPES];
    logic [CNT_W-1:0]    r_dec_mem  [swl_pkg::NUM_TYPES];
    swl_pkg::t_slot      r_slot_mem [swl_pkg::WINDOW_MAX];

    logic [CNT_W-1:0]    r_inc_a, r_dec_a, r_inc_b, r_dec_b;
    swl_pkg::t_slot      r_slot_rd;

    logic                inc_we, dec_we, slot_we;
    logic [TYPE_W-1:0]   inc_wa, dec_wa;
    logic [CNT_W-1:0]    inc_wd, dec_wd;
    logic [POS_W-1:0]    slot_wa;
    swl_pkg::t_slot      slot_wd;

    // Last write of each memory, to cover reads that missed it
    logic                r_inc_lw_en, r_dec_lw_en, r_slot_lw_en;
    logic [TYPE_W-1:0]   r_inc_lw_addr, r_dec_lw_addr;
    logic [CNT_W-1:0]    r_inc_lw_data, r_dec_lw_data;
    logic [POS_W-1:0]    r_slot_lw_addr;
    swl_pkg::t_slot      r_slot_lw_data;

    // ------------------------------------------------------------------
    // Clearing sweep and front-end state
    // ------------------------------------------------------------------
    logic                r_clr;
    logic [TYPE_W-1:0]   r_clr_addr;
    logic [POS_W-1:0]    r_wp;
    logic [SEEN_W-1:0]   r_seen;
    logic [TOTAL_W-1:0]  r_total;

    logic                in_acc;
    logic [TYPE_W-1:0]   kind_in;
    logic [SEEN_W-1:0]   w_eff;
    logic [SEEN_W-1:0]   w_m1;
    logic [POS_W-1:0]    back_in;

    logic [QCNT_W-1:0]   q_count;
    logic                q_valid;
    logic                q_pop;
    swl_pkg::t_result    q_data;
    swl_pkg::t_result    push_data;

    // Stage 1 and stage 2 registers
    logic                r_v1, r_leave1, r_self1;
    logic [TYPE_W-1:0]   r_kind1;
    logic [POS_W-1:0]    r_pos1, r_back1;
    logic                r_v2, r_dl2;
    logic [TYPE_W-1:0]   r_t2;

    always_comb begin
        if (r_wl == '0) begin
            w_eff = SEEN_W'(1);
        end else if (SEEN_W'(r_wl) > SEEN_W'(swl_pkg::WINDOW_MAX)) begin
            w_eff = SEEN_W'(swl_pkg::WINDOW_MAX);
        end else begin
            w_eff = SEEN_W'(r_wl);
        end
    end

    assign w_m1    = w_eff - 1'b1;
    assign back_in = r_wp - w_m1[POS_W-1:0];
    assign kind_in = i_arrival_type[TYPE_W-1:0];
    assign o_stall = r_clr || ((q_count + QCNT_W'(r_v1)) >= QCNT_W'(swl_pkg::OUT_DEPTH));
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_seen     <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == TYPE_W'(swl_pkg::NUM_TYPES - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (in_acc) begin
                r_wp <= r_wp + 1'b1;
                if (r_seen < SEEN_W'(swl_pkg::WINDOW_MAX)) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= in_acc;
            r_v2 <= r_v1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: check the arrival against its count, record its slot,
    // find the leaving slot
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]    inc_k, dec_k, count_k;
    logic [CNT_W:0]      cnt_next;
    logic                drop;
    swl_pkg::t_slot      cur_slot, slot_fwd, leave_slot;
    logic                dleave1;
    logic [TOTAL_W-1:0]  n_total;

    // Stage 2 terms used for forwarding into stage 1
    logic [CNT_W-1:0]    inc_t, dec_t;

    always_comb begin
        inc_k = r_inc_a;
        if (r_inc_lw_en && r_inc_lw_addr == r_kind1) begin
            inc_k = r_inc_lw_data;
        end

        // Stage 2 writes this cycle belong to an older word: take them first
        priority if (dec_we && dec_wa == r_kind1) begin
            dec_k = dec_wd;
        end else if (r_dec_lw_en && r_dec_lw_addr == r_kind1) begin
            dec_k = r_dec_lw_data;
        end else begin
            dec_k = r_dec_a;
        end

        count_k  = inc_k - dec_k;
        cnt_next = {1'b0, count_k} + 1'b1;
        drop     = cnt_next > {1'b0, r_mpt};

        cur_slot.kept = !drop;
        cur_slot.kind = r_kind1;

        slot_fwd = r_slot_rd;
        if (r_slot_lw_en && r_slot_lw_addr == r_back1) begin
            slot_fwd = r_slot_lw_data;
        end
        // A one-word window drops the word's own slot
        leave_slot = r_self1 ? cur_slot : slot_fwd;
        dleave1    = r_leave1 && leave_slot.kept;

        n_total = r_total;
        if (drop && r_total != '1) begin
            n_total = r_total + 1'b1;
        end

        push_data.discarded     = drop;
        push_data.discard_total = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (r_v1) begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind1  <= kind_in;
            r_pos1   <= r_wp;
            r_back1  <= back_in;
            r_leave1 <= r_seen >= w_m1;
            r_self1  <= (w_m1 == '0);
        end
        r_t2  <= leave_slot.kind;
        r_dl2 <= dleave1;
    end

    // ------------------------------------------------------------------
    // Stage 2: retire the leaving word's type
    // ------------------------------------------------------------------
    always_comb begin
        inc_t = r_inc_b;
        if (r_inc_lw_en && r_inc_lw_addr == r_t2) begin
            inc_t = r_inc_lw_data;
        end
        dec_t = r_dec_b;
        if (r_dec_lw_en && r_dec_lw_addr == r_t2) begin
            dec_t = r_dec_lw_data;
        end
    end

    // Memory write ports; the sweep owns both count memories after reset
    always_comb begin
        if (r_clr) begin
            inc_we = 1'b1;
            inc_wa = r_clr_addr;
            inc_wd = '0;
            dec_we = 1'b1;
            dec_wa = r_clr_addr;
            dec_wd = '0;
        end else begin
            inc_we = r_v1 && !drop;
            inc_wa = r_kind1;
            inc_wd = cnt_next[CNT_W-1:0] + dec_k;
            // hold the count at zero if the leaving type already reads empty
            dec_we = r_v2 && r_dl2 && (inc_t != dec_t);
            dec_wa = r_t2;
            dec_wd = dec_t + 1'b1;
        end
        slot_we = r_v1;
        slot_wa = r_pos1;
        slot_wd = cur_slot;
    end

    always_ff @(posedge i_clk) begin
        r_inc_a <= r_inc_mem[kind_in];
        r_inc_b <= r_inc_mem[leave_slot.kind];
        if (inc_we) begin
            r_inc_mem[inc_wa] <= inc_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec_a <= r_dec_mem[kind_in];
        r_dec_b <= r_dec_mem[leave_slot.kind];
        if (dec_we) begin
            r_dec_mem[dec_wa] <= dec_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_rd <= r_slot_mem[back_in];
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_lw_en  <= 1'b0;
            r_dec_lw_en  <= 1'b0;
            r_slot_lw_en <= 1'b0;
        end else begin
            r_inc_lw_en  <= inc_we;
            r_dec_lw_en  <= dec_we;
            r_slot_lw_en <= slot_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inc_lw_addr  <= inc_wa;
        r_inc_lw_data  <= inc_wd;
        r_dec_lw_addr  <= dec_wa;
        r_dec_lw_data  <= dec_wd;
        r_slot_lw_addr <= slot_wa;
        r_slot_lw_data <= slot_wd;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign q_pop = q_valid && !i_stall;

    swl_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v1),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    assign o_valid         = q_valid;
    assign o_discarded     = q_data.discarded;
    assign o_discard_total = q_data.discard_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_clr)
        else $error("word accepted during count memory sweep");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (q_count != QCNT_W'(swl_pkg::OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n)) |-> (r_total >= $past(r_total)))
        else $error("discard total went backwards");

    a_no_retire_in_stage1_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr && dec_we) |-> r_v2)
        else $error("count retired without a word in stage 2");

endmodule
`default_nettype wire

/* sv/swl_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swl_out_fifo: result queue of the limiter
// Small register queue that decouples the result side from the count
// pipeline; the occupancy goes back to the core for input flow control.
// ----------------------------------------------------------------------------
module swl_out_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire swl_pkg::t_result              i_data,
    input  wire logic                          i_pop,
    output swl_pkg::t_result                   o_data,
    output logic                               o_valid,
    output logic [swl_pkg::OUT_PTR_W:0]        o_count
);

    swl_pkg::t_result                 r_mem [swl_pkg::OUT_DEPTH];
    logic [swl_pkg::OUT_PTR_W-1:0]    r_wr;
    logic [swl_pkg::OUT_PTR_W-1:0]    r_rd;
    logic [swl_pkg::OUT_PTR_W:0]      r_count;
    logic [swl_pkg::OUT_PTR_W:0]      n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

/* tb/sv/tb_sliding_window_per_type_limiter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sliding_window_per_type_limiter: self-checking bench for the limiter
// A queue-fed driver offers arrival words with random gaps, and a monitor
// checks each result word against an in-bench model of the per-type window
// counts. The run steps through several register settings, including zero
// and oversized values, and stalls the output long enough to back up input.
// ----------------------------------------------------------------------------
module tb_sliding_window_per_type_limiter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [swl_pkg::ARR_W-1:0]     i_arrival_type = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_discarded;
    logic [swl_pkg::TOTAL_W-1:0]   o_discard_total;
    logic                          i_cfg_we = 1'b0;
    logic [swl_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [swl_pkg::CFG_W-1:0]     i_cfg_data = '0;

    sliding_window_per_type_limiter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_arrival_type  (i_arrival_type),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_discarded     (o_discarded),
        .o_discard_total (o_discard_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Model state and register copies
    logic [swl_pkg::CFG_W-1:0]   cfg_window_length = swl_pkg::CFG_W'(1);
    logic [swl_pkg::CFG_W-1:0]   cfg_max_per_type  = swl_pkg::CFG_W'(1);
    int unsigned                 type_count [swl_pkg::NUM_TYPES];
    logic                        slot_kept  [swl_pkg::WINDOW_MAX];
    logic [swl_pkg::TYPE_W-1:0]  slot_kind  [swl_pkg::WINDOW_MAX];
    int unsigned                 ring_pos = 0;
    int unsigned                 seen = 0;
    logic [swl_pkg::TOTAL_W-1:0] drop_total = '0;

    logic [swl_pkg::ARR_W-1:0]   pending_arrivals [$];
    swl_pkg::t_result            expected_results [$];

    int                  mismatches = 0;
    bit                  idle_en = 1'b1;
    bit                  long_hold_armed = 1'b0;
    bit                  long_hold_done = 1'b0;
    int                  send_gap = 0;
    int                  recv_gap = 0;
    int                  long_hold_left = 0;
    int                  cycle_count = 0;

    function automatic swl_pkg::t_result limit_arrival(
        input logic [swl_pkg::ARR_W-1:0] arrival);
        swl_pkg::t_result           res;
        logic [swl_pkg::TYPE_W-1:0] kind;
        int unsigned                span;
        int unsigned                back;
        int unsigned                next_count;
        logic                       drop;
        kind = swl_pkg::TYPE_W'(arrival);
        span = (cfg_window_length == '0) ? 1 : 32'(cfg_window_length);
        if (span > swl_pkg::WINDOW_MAX) span = swl_pkg::WINDOW_MAX;
        next_count = type_count[kind] + 1;
        drop = next_count > cfg_max_per_type;
        if (drop) begin
            if (drop_total != '1) drop_total = drop_total + 1;
        end else begin
            type_count[kind] = next_count;
        end
        slot_kind[ring_pos] = kind;
        slot_kept[ring_pos] = !drop;
        // retire the word leaving the window, measured at the current length
        if (seen >= span - 1) begin
            back = (ring_pos + swl_pkg::WINDOW_MAX - (span - 1)) % swl_pkg::WINDOW_MAX;
            if (slot_kept[back] && type_count[slot_kind[back]] != 0)
                type_count[slot_kind[back]] = type_count[slot_kind[back]] - 1;
        end
        ring_pos = (ring_pos + 1) % swl_pkg::WINDOW_MAX;
        if (seen < swl_pkg::WINDOW_MAX) seen = seen + 1;
        res.discarded     = drop;
        res.discard_total = drop_total;
        return res;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall)
                expected_results.push_back(limit_arrival(i_arrival_type));
            // hold a stalled word; otherwise pick the next one or idle
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_arrivals.size() > 0 && idle_en
                             && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 7) - 1;
                    i_valid <= 1'b0;
                end else if (pending_arrivals.size() > 0) begin
                    i_valid <= 1'b1;
                    i_arrival_type <= pending_arrivals.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        swl_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no arrival pending");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_discarded !== want.discarded) begin
                        $error("discarded: expected %0d, actual %0d",
                               want.discarded, o_discarded);
                        mismatches++;
                    end
                    if (o_discard_total !== want.discard_total) begin
                        $error("discard_total: expected %0d, actual %0d",
                               want.discard_total, o_discard_total);
                        mismatches++;
                    end
                end
            end
            if (long_hold_armed && !long_hold_done) begin
                long_hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (long_hold_left > 0) begin
                long_hold_left = long_hold_left - 1;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                i_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(1, 7) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(input logic [swl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swl_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == swl_pkg::REG_WINDOW_LENGTH)
            cfg_window_length = data;
        else if (idx == swl_pkg::REG_MAX_PER_TYPE)
            cfg_max_per_type = data;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_arrivals.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly a narrow pool of types so the per-type limit bites
    task automatic queue_random(input int count, input int pool_hi);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                pending_arrivals.push_back(swl_pkg::ARR_W'($urandom_range(0, pool_hi)));
            else if (pick < 7)
                pending_arrivals.push_back(
                    swl_pkg::ARR_W'(1023 - $urandom_range(0, pool_hi)));
            else
                pending_arrivals.push_back(swl_pkg::ARR_W'($urandom_range(0, 1023)));
        end
    endtask

    initial begin
        for (int k = 0; k < swl_pkg::NUM_TYPES; k++) type_count[k] = 0;
        for (int k = 0; k < swl_pkg::WINDOW_MAX; k++) begin
            slot_kept[k] = 1'b0;
            slot_kind[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, window of one
        pending_arrivals.push_back(swl_pkg::ARR_W'(0));
        pending_arrivals.push_back(swl_pkg::ARR_W'(1023));
        pending_arrivals.push_back(swl_pkg::ARR_W'(0));
        pending_arrivals.push_back(swl_pkg::ARR_W'(0));
        drain();
        // same type repeated past the limit
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(4));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(2));
        repeat (5) pending_arrivals.push_back(swl_pkg::ARR_W'(5));
        pending_arrivals.push_back(swl_pkg::ARR_W'(6));
        drain();
        // zero limit drops everything
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(0));
        pending_arrivals.push_back(swl_pkg::ARR_W'(1));
        pending_arrivals.push_back(swl_pkg::ARR_W'(2));
        drain();
        // zero window acts as one
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(0));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(1));
        pending_arrivals.push_back(swl_pkg::ARR_W'(3));
        pending_arrivals.push_back(swl_pkg::ARR_W'(3));
        drain();
        // oversized window clamps; out-of-range indexes are ignored
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(511));
        write_reg(swl_pkg::CFG_IDX_W'(2), swl_pkg::CFG_W'(0));
        write_reg(swl_pkg::CFG_IDX_W'(3), swl_pkg::CFG_W'(0));
        pending_arrivals.push_back(swl_pkg::ARR_W'(7));
        pending_arrivals.push_back(swl_pkg::ARR_W'(7));
        pending_arrivals.push_back(swl_pkg::ARR_W'(1023));
        pending_arrivals.push_back(swl_pkg::ARR_W'(1023));
        drain();

        // Random phases; state carries over so the window shifts mid-stream
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(16));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(2));
        long_hold_armed = 1'b1;
        queue_random(50, 7);
        drain();
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(256));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(256));
        queue_random(45, 3);
        drain();
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(1));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(1));
        queue_random(40, 3);
        drain();
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(300));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(3));
        queue_random(45, 7);
        drain();
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(8));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(511));
        queue_random(40, 15);
        drain();
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(64));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(1));
        queue_random(45, 31);
        drain();
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(0));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(0));
        queue_random(25, 3);
        drain();
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(32));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(4));
        queue_random(50, 5);
        drain();
        // back-to-back, no idling
        idle_en = 1'b0;
        write_reg(swl_pkg::REG_WINDOW_LENGTH, swl_pkg::CFG_W'(12));
        write_reg(swl_pkg::REG_MAX_PER_TYPE, swl_pkg::CFG_W'(2));
        queue_random(60, 5);
        drain();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

/* sliding_window_per_type_limiter.f */
sv/swl_pkg.sv
sv/swl_out_fifo.sv
sv/sliding_window_per_type_limiter.sv
tb/sv/tb_sliding_window_per_type_limiter.sv
